[src/tst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the temperature slew tracker.
// No dependencies; used by tst_mul, tst_slew and the core.
package tst_pkg;

    localparam int SAMPLE_W = 10;
    localparam int OPND_W   = 16;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int TEMP_W   = 8;
    localparam int TARGET_W = 15;

    localparam logic [OPND_W-1:0] REF_SCALE_RST = 16'd256;
    localparam logic [OPND_W-1:0] VOLT_LOW      = 16'd400;
    localparam logic [OPND_W-1:0] VOLT_HIGH     = 16'd950;
    localparam logic [OPND_W-1:0] VOLT_OFFSET   = 16'd535;
    localparam logic [OPND_W-1:0] TEMP_GAIN     = 16'd108;
    localparam logic [TEMP_W-1:0] TEMP_MID      = 8'd50;
    localparam logic [TEMP_W-1:0] BELOW_MARK    = 8'd128;
    localparam logic [TEMP_W-1:0] TEMP_MAX      = 8'd255;
    localparam logic [TEMP_W-1:0] DWELL_STEP    = 8'd2;
    localparam logic [TEMP_W-1:0] DWELL_RELOAD  = 8'd255;

    // Request from the sequencer to the slew tracker
    typedef struct packed {
        logic                update;
        logic [TARGET_W-1:0] target;
    } slew_req_t;

    // Temperature after the pending update
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [TEMP_W-1:0] temp_signed;
    } slew_res_t;

endpackage

[src/tst_mul.sv]
`timescale 1ns / 1ps
// Shared 16x16 unsigned multiplier with a product register loaded on each pass.
// Depends on tst_pkg for operand and product widths.
module tst_mul
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [tst_pkg::OPND_W-1:0]  op_a,
    input  logic [tst_pkg::OPND_W-1:0]  op_b,
    output logic [tst_pkg::PROD_W-1:0]  product
);

    logic [tst_pkg::PROD_W-1:0] product_reg;
    logic [tst_pkg::PROD_W-1:0] product_next;

    // Form the full-width product
    assign product_next = {{tst_pkg::OPND_W{1'b0}}, op_a} * {{tst_pkg::OPND_W{1'b0}}, op_b};

    // Load the product on a multiply pass, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

[src/tst_slew.sv]
`timescale 1ns / 1ps
// Slew-limited temperature tracker: kept temperature and rise/fall dwell counters.
// Depends on tst_pkg for the request/result structs and constants.
module tst_slew
(
    input  logic               clk,
    input  logic               rst_n,
    input  tst_pkg::slew_req_t req,
    output tst_pkg::slew_res_t res
);

    logic [tst_pkg::TEMP_W-1:0] tracked_reg;
    logic [tst_pkg::TEMP_W-1:0] tracked_next;
    logic [tst_pkg::TEMP_W-1:0] rise_dwell_reg;
    logic [tst_pkg::TEMP_W-1:0] rise_dwell_next;
    logic [tst_pkg::TEMP_W-1:0] fall_dwell_reg;
    logic [tst_pkg::TEMP_W-1:0] fall_dwell_next;
    logic [tst_pkg::TARGET_W-1:0] tracked_wide;

    assign tracked_wide = {{(tst_pkg::TARGET_W - tst_pkg::TEMP_W){1'b0}}, tracked_reg};

    // Step toward the target after the dwell runs out
    always_comb
    begin
        tracked_next    = tracked_reg;
        rise_dwell_next = rise_dwell_reg;
        fall_dwell_next = fall_dwell_reg;
        if (req.target > tracked_wide)
        begin
            fall_dwell_next = tst_pkg::DWELL_RELOAD;
            if (rise_dwell_reg != '0)
            begin
                rise_dwell_next = rise_dwell_reg - 8'd1;
            end
            else
            begin
                // hold at full scale instead of wrapping
                if (tracked_reg != tst_pkg::TEMP_MAX)
                begin
                    tracked_next = tracked_reg + 8'd1;
                end
                rise_dwell_next = tst_pkg::DWELL_STEP;
            end
        end
        else if (req.target < tracked_wide)
        begin
            rise_dwell_next = tst_pkg::DWELL_RELOAD;
            if (fall_dwell_reg != '0)
            begin
                fall_dwell_next = fall_dwell_reg - 8'd1;
            end
            else
            begin
                fall_dwell_next = tst_pkg::DWELL_STEP;
                tracked_next    = tracked_reg - 8'd1;
            end
        end
    end

    // Advance the tracker state on an update strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg    <= '0;
            rise_dwell_reg <= '0;
            fall_dwell_reg <= '0;
        end
        else if (req.update)
        begin
            tracked_reg    <= tracked_next;
            rise_dwell_reg <= rise_dwell_next;
            fall_dwell_reg <= fall_dwell_next;
        end
    end

    // Present the post-update temperature in both forms
    always_comb
    begin
        res.temp = tracked_next;
        if (tracked_next >= tst_pkg::TEMP_MID)
        begin
            res.temp_signed = tracked_next - tst_pkg::TEMP_MID;
        end
        else
        begin
            res.temp_signed = (tst_pkg::TEMP_MID - tracked_next) + tst_pkg::BELOW_MARK;
        end
    end

endmodule

[src/temperature_slew_tracker_core.sv]
`timescale 1ns / 1ps
// Top level of the temperature slew tracker: sequencer, config register, output register.
// Depends on tst_pkg, tst_mul and tst_slew.

// A sensor sample is taken while the block is idle. It then makes two passes through
// the single shared 16x16 multiplier (sample times reference_scale, then excess
// voltage times the gain) and an update step that updates the tracker and loads the
// output register, so no new sample is taken until the update step completes.
// in_stall is high from the transfer until the update step completes. If the previous
// result is still stalled when the update step is reached, the block waits there,
// holding the second product, until that result is taken.
// reference_scale resets to 256 and the user must write it with cfg_write_en only
// while idle; the block itself does not enforce this.
module temperature_slew_tracker_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [tst_pkg::OPND_W-1:0]    cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tst_pkg::SAMPLE_W-1:0]  sensor_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tst_pkg::TEMP_W-1:0]    temperature,
    output logic [tst_pkg::TEMP_W-1:0]    temperature_signed,
    output logic                          sensor_fault
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_GAIN,
        ST_UPDATE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [tst_pkg::OPND_W-1:0]    ref_scale_reg;
    logic [tst_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                          fault_reg;
    logic                          fault_next;
    logic                          out_valid_reg;
    logic [tst_pkg::TEMP_W-1:0]    temp_reg;
    logic [tst_pkg::TEMP_W-1:0]    temp_signed_reg;
    logic                          out_fault_reg;

    logic [tst_pkg::OPND_W-1:0]    op_a;
    logic [tst_pkg::OPND_W-1:0]    op_b;
    logic [tst_pkg::PROD_W-1:0]    product;
    logic                          mul_load;
    logic [tst_pkg::OPND_W-1:0]    volt;
    logic [tst_pkg::OPND_W-1:0]    excess;
    logic                          in_xfer;
    logic                          out_free;
    logic                          load_out;
    tst_pkg::slew_req_t            slew_req;
    tst_pkg::slew_res_t            slew_res;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_UPDATE) && out_free;
    assign mul_load = (state_reg == ST_SCALE) || (state_reg == ST_GAIN);

    // Hold the calibration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_scale_reg <= tst_pkg::REF_SCALE_RST;
        end
        else if (cfg_write_en)
        begin
            ref_scale_reg <= cfg_write_data;
        end
    end

    // Derive voltage, fault and excess from the first product
    assign volt       = product[tst_pkg::OPND_W+7:8];
    assign fault_next = (volt < tst_pkg::VOLT_LOW) || (volt > tst_pkg::VOLT_HIGH);
    assign excess     = (volt >= tst_pkg::VOLT_OFFSET) ? (volt - tst_pkg::VOLT_OFFSET) : '0;

    // Select the multiplier operands for each pass
    always_comb
    begin
        case (state_reg)
            ST_SCALE:
            begin
                op_a = {{(tst_pkg::OPND_W - tst_pkg::SAMPLE_W){1'b0}}, sample_reg};
                op_b = ref_scale_reg;
            end
            ST_GAIN:
            begin
                op_a = excess;
                op_b = tst_pkg::TEMP_GAIN;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    tst_mul u_mul
    (
        .clk     (clk),
        .load    (mul_load),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    // Request a tracker update with the target from the second product
    assign slew_req.update = load_out;
    assign slew_req.target = product[tst_pkg::TARGET_W+7:8];

    tst_slew u_slew
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (slew_req),
        .res   (slew_res)
    );

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Hold state, captured sample and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            sample_reg      <= '0;
            fault_reg       <= 1'b0;
            temp_reg        <= '0;
            temp_signed_reg <= '0;
            out_fault_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                sample_reg <= sensor_sample;
            end
            if (state_reg == ST_GAIN)
            begin
                fault_reg <= fault_next;
            end
            if (load_out)
            begin
                out_valid_reg   <= 1'b1;
                temp_reg        <= slew_res.temp;
                temp_signed_reg <= slew_res.temp_signed;
                out_fault_reg   <= fault_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign temperature        = temp_reg;
    assign temperature_signed = temp_signed_reg;
    assign sensor_fault       = out_fault_reg;

endmodule
